// ===== hw/rtl/hav_pkg.sv =====
// ----------------------------------------------------------------------------
// hav_pkg
// shared types, fixed-point constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package hav_pkg;

	typedef logic signed [63:0] q60_t;

	localparam int CORDIC_STEPS = 48;

	localparam q60_t PI_Q60   = 64'sh3243F6A8885A308D;
	localparam q60_t KINV_Q60 = 64'sd700114967507363296;
	localparam q60_t RADIUS_M = 64'sd6371000;

	localparam int LAT_W  = 21;
	localparam int LON_W  = 22;
	localparam int DIST_W = 25;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 22;

	localparam logic [DIST_W-1:0] DIST_MAX = 25'd20015087;

	localparam logic [CFG_IDX_W-1:0] REG_REF_LAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_LON = 2'd1;

	localparam logic signed [LAT_W-1:0] REF_LAT_RESET = 21'sd115710;
	localparam logic signed [LON_W-1:0] REF_LON_RESET = 22'sd1048970;

	// shift-subtract division, elaboration only
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(2^-i) in q60, alternating taylor series with floored terms
	function automatic q60_t atan_q60(int i);
		q60_t sum;
		q60_t term;
		int e;
		sum = '0;
		if (i == 0) begin
			sum = PI_Q60 >>> 2;
		end else begin
			for (int k = 0; k < 31; k++) begin
				e = 60 - i * (2 * k + 1);
				if (e >= 0) begin
					term = q60_t'(udiv64(64'd1 << e, 64'(2 * k + 1)));
					sum = (k % 2 == 1) ? sum - term : sum + term;
				end
			end
		end
		return sum;
	endfunction

endpackage

// ===== hw/rtl/hav_cordic.sv =====
// ----------------------------------------------------------------------------
// hav_cordic
// unrolled cordic, one micro-rotation per register stage, rotation or vectoring
// ----------------------------------------------------------------------------
module hav_cordic #(
	parameter int STEPS  = hav_pkg::CORDIC_STEPS,
	parameter bit VECTOR = 1'b0,
	parameter int SW     = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  hav_pkg::q60_t x_in,
	input  hav_pkg::q60_t y_in,
	input  hav_pkg::q60_t z_in,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output hav_pkg::q60_t x_out,
	output hav_pkg::q60_t y_out,
	output hav_pkg::q60_t z_out,
	output logic [SW-1:0] side_out
);
	import hav_pkg::*;

	logic          v_s    [STEPS+1];
	q60_t          x_s    [STEPS+1];
	q60_t          y_s    [STEPS+1];
	q60_t          z_s    [STEPS+1];
	logic [SW-1:0] side_s [STEPS+1];

	// entry stage, magnitudes in vectoring mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (VECTOR) begin
				x_s[0] <= (x_in < 0) ? -x_in : x_in;
				y_s[0] <= (y_in < 0) ? -y_in : y_in;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
			end
			z_s[0]    <= z_in;
			side_s[0] <= side_in;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam q60_t ATAN = atan_q60(i);
		q60_t dx;
		q60_t dy;
		logic dir;

		assign dx  = y_s[i] >>> i;
		assign dy  = x_s[i] >>> i;
		assign dir = VECTOR ? (y_s[i] > 0) : (z_s[i] >= 0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (VECTOR == dir) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ATAN;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ATAN;
				end
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign x_out     = x_s[STEPS];
	assign y_out     = y_s[STEPS];
	assign z_out     = z_s[STEPS];
	assign side_out  = side_s[STEPS];

endmodule

// ===== hw/rtl/hav_qmul.sv =====
// ----------------------------------------------------------------------------
// hav_qmul
// q60 product rounded half away from zero, 32x32 partial products, 5 stages
// ----------------------------------------------------------------------------
module hav_qmul #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  hav_pkg::q60_t a,
	input  hav_pkg::q60_t b,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output hav_pkg::q60_t p,
	output logic [SW-1:0] side_out
);
	import hav_pkg::*;

	localparam logic [127:0] HALF_LSB = 128'd1 << 59;

	logic [4:0]    v_q;
	logic          neg_s1, neg_s2, neg_s3, neg_s4;
	logic [63:0]   ua_s1, ub_s1;
	logic [63:0]   p0_s2, p1_s2, p2_s2, p3_s2;
	logic [64:0]   mid_s3;
	logic [127:0]  lohi_s3;
	logic [127:0]  full_s4;
	q60_t          p_s5;
	logic [SW-1:0] side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [63:0]   mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[3:0], in_valid};
		end
	end

	assign mag = (full_s4[123] == 1'b1) ? 64'h7FFF_FFFF_FFFF_FFFF : full_s4[123:60];

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= (a < 0) != (b < 0);
			ua_s1   <= (a < 0) ? 64'(-a) : 64'(a);
			ub_s1   <= (b < 0) ? 64'(-b) : 64'(b);
			side_s1 <= side_in;

			neg_s2  <= neg_s1;
			p0_s2   <= ua_s1[31:0] * ub_s1[31:0];
			p1_s2   <= ua_s1[31:0] * ub_s1[63:32];
			p2_s2   <= ua_s1[63:32] * ub_s1[31:0];
			p3_s2   <= ua_s1[63:32] * ub_s1[63:32];
			side_s2 <= side_s1;

			neg_s3  <= neg_s2;
			mid_s3  <= {1'b0, p1_s2} + {1'b0, p2_s2};
			lohi_s3 <= {p3_s2, p0_s2};
			side_s3 <= side_s2;

			neg_s4  <= neg_s3;
			full_s4 <= lohi_s3 + {31'd0, mid_s3, 32'd0} + HALF_LSB;
			side_s4 <= side_s3;

			p_s5    <= neg_s4 ? -q60_t'(mag) : q60_t'(mag);
			side_s5 <= side_s4;
		end
	end

	assign out_valid = v_q[4];
	assign p         = p_s5;
	assign side_out  = side_s5;

endmodule

// ===== hw/rtl/haversine_distance_core.sv =====
// ----------------------------------------------------------------------------
// haversine_distance_core
// great-circle distance in metres from a reference point, cordic pipeline
// ----------------------------------------------------------------------------
// channel  dir  content
// s_*      in   tdata: pos_latitude [20:0], pos_longitude [42:21]
// m_*      out  tdata: distance_m [24:0]
// cfg_*    in   index 0 ref_latitude, index 1 ref_longitude
//
// one item per cycle while the output is not stalled; the datapath is four chained
// cordic pipelines and four 5-stage multipliers
// arst_n clears valid bits and loads the reference point reset values
// a stalled output freezes every stage together, s_tready follows
// ----------------------------------------------------------------------------
module haversine_distance_core #(
	parameter int STEPS = hav_pkg::CORDIC_STEPS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [hav_pkg::IN_TDATA_W-1:0]   s_tdata,  // pos_latitude, pos_longitude
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [hav_pkg::OUT_TDATA_W-1:0]  m_tdata,  // distance_m
	input  logic                             cfg_we,
	input  logic [hav_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hav_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import hav_pkg::*;

	localparam int TURN    = 3600000;
	localparam int QUARTER = 900000;
	localparam int HALF_T  = 1800000;
	localparam int THREEQ  = 2700000;
	localparam logic [60:0] PQ   = 61'(PI_Q60 / HALF_T);
	localparam logic [20:0] PR   = 21'(PI_Q60 % HALF_T);
	localparam int          DIVQ = HALF_T / 64;
	localparam logic [21:0] RECIP = 22'(((64'd1 << 36) + DIVQ - 1) / DIVQ);
	localparam q60_t HALF_PI = PI_Q60 >>> 1;

	typedef struct packed {
		logic [1:0]  quad;
		logic [19:0] rem;
	} red_t;

	function automatic red_t reduce(logic signed [22:0] t);
		logic signed [24:0] w;
		logic [21:0] r;
		red_t o;
		w = 25'(t);
		priority if (w < -TURN) begin
			r = 22'(w + 2 * TURN);
		end else if (w < 0) begin
			r = 22'(w + TURN);
		end else if (w >= TURN) begin
			r = 22'(w - TURN);
		end else begin
			r = 22'(w);
		end
		priority if (r < QUARTER) begin
			o.quad = 2'd0;
			o.rem  = 20'(r);
		end else if (r < HALF_T) begin
			o.quad = 2'd1;
			o.rem  = 20'(r - 22'(QUARTER));
		end else if (r < THREEQ) begin
			o.quad = 2'd2;
			o.rem  = 20'(r - 22'(HALF_T));
		end else begin
			o.quad = 2'd3;
			o.rem  = 20'(r - 22'(THREEQ));
		end
		return o;
	endfunction

	logic adv;
	logic signed [LAT_W-1:0] ref_latitude_q;
	logic signed [LON_W-1:0] ref_longitude_q;
	logic signed [LAT_W-1:0] pos_latitude;
	logic signed [LON_W-1:0] pos_longitude;
	logic signed [22:0] ang [3];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	red_t        red_s1   [3];
	logic [60:0] pa_s2    [3];
	logic [34:0] py_s2    [3];
	logic [1:0]  quad_s2  [3];
	logic [60:0] pa_s3    [3];
	logic [34:0] py_s3    [3];
	logic [20:0] qh_s3    [3];
	logic [1:0]  quad_s3  [3];
	logic [60:0] pa_s4    [3];
	logic [34:0] py_s4    [3];
	logic [20:0] qh_s4    [3];
	logic [35:0] chk_s4   [3];
	logic [1:0]  quad_s4  [3];
	q60_t        theta_s5 [3];
	logic [1:0]  quad_s5  [3];
	logic [2:0]  rot_v;
	q60_t        rot_x    [3];
	q60_t        rot_y    [3];
	logic [1:0]  rot_q    [3];
	q60_t        sn_s6    [3];
	q60_t        cs_s6    [3];

	logic [1:0]   mul_v;
	q60_t         ax, ay;
	logic [191:0] ms_side;
	q60_t         dx_s7, ux_s7, ay_s7, ds_s7, us_s7;

	logic [1:0] va_v, ka_v, vb_v, kb_v;
	q60_t va_x [2];
	q60_t va_s [2];
	q60_t ka_p [2];
	q60_t ka_s [2];
	q60_t vb_x [2];
	q60_t kb_p [2];
	logic vc_v, kc_v;
	q60_t vc_z, c_s8, kc_p;
	logic out_valid_q;
	logic [DIST_W-1:0] dist_q;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;
	assign pos_latitude  = s_tdata[LAT_W-1:0];
	assign pos_longitude = s_tdata[LAT_W+LON_W-1:LAT_W];

	// reference point registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_latitude_q  <= REF_LAT_RESET;
			ref_longitude_q <= REF_LON_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_REF_LAT) begin
				ref_latitude_q <= cfg_data[LAT_W-1:0];
			end
			if (cfg_index == REG_REF_LON) begin
				ref_longitude_q <= cfg_data[LON_W-1:0];
			end
		end
	end

	assign ang[0] = 23'(ref_latitude_q);
	assign ang[1] = 23'(pos_latitude);
	assign ang[2] = 23'(pos_longitude) - 23'(ref_longitude_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= &rot_v;
			v_s7 <= &mul_v;
			v_s8 <= vc_v;
			out_valid_q <= kc_v;
		end
	end

	// angle to quadrant and q60 radians, then sin/cos
	for (genvar l = 0; l < 3; l++) begin : g_ang
		always_ff @(posedge clk) begin
			if (adv) begin
				red_s1[l]   <= reduce(ang[l]);

				pa_s2[l]    <= 61'(red_s1[l].rem) * PQ;
				py_s2[l]    <= 35'((41'(red_s1[l].rem) * 41'(PR)) >> 6);
				quad_s2[l]  <= red_s1[l].quad;

				pa_s3[l]    <= pa_s2[l];
				py_s3[l]    <= py_s2[l];
				qh_s3[l]    <= 21'((57'(py_s2[l]) * 57'(RECIP)) >> 36);
				quad_s3[l]  <= quad_s2[l];

				pa_s4[l]    <= pa_s3[l];
				py_s4[l]    <= py_s3[l];
				qh_s4[l]    <= qh_s3[l];
				chk_s4[l]   <= 36'(qh_s3[l]) * 36'(DIVQ);
				quad_s4[l]  <= quad_s3[l];

				theta_s5[l] <= q60_t'(pa_s4[l]) + q60_t'((chk_s4[l] > 36'(py_s4[l]))
					? qh_s4[l] - 21'd1 : qh_s4[l]);
				quad_s5[l]  <= quad_s4[l];
			end
		end

		hav_cordic #(.STEPS(STEPS), .VECTOR(1'b0), .SW(2)) u_rot (
			.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s5),
			.x_in(KINV_Q60), .y_in('0), .z_in(theta_s5[l]), .side_in(quad_s5[l]),
			.out_valid(rot_v[l]), .x_out(rot_x[l]), .y_out(rot_y[l]), .z_out(),
			.side_out(rot_q[l])
		);

		always_ff @(posedge clk) begin
			if (adv) begin
				unique case (rot_q[l])
					2'd0: begin
						cs_s6[l] <= rot_x[l];
						sn_s6[l] <= rot_y[l];
					end
					2'd1: begin
						cs_s6[l] <= -rot_y[l];
						sn_s6[l] <= rot_x[l];
					end
					2'd2: begin
						cs_s6[l] <= -rot_x[l];
						sn_s6[l] <= -rot_y[l];
					end
					default: begin
						cs_s6[l] <= rot_y[l];
						sn_s6[l] <= -rot_x[l];
					end
				endcase
			end
		end
	end

	// position unit vector in the reference longitude frame
	hav_qmul #(.SW(192)) u_mul_ax (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s6),
		.a(cs_s6[1]), .b(cs_s6[2]), .side_in({cs_s6[0], sn_s6[0], sn_s6[1]}),
		.out_valid(mul_v[0]), .p(ax), .side_out(ms_side)
	);

	hav_qmul #(.SW(1)) u_mul_ay (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s6),
		.a(cs_s6[1]), .b(sn_s6[2]), .side_in(1'b0),
		.out_valid(mul_v[1]), .p(ay), .side_out()
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s7 <= ax - ms_side[191:128];
			ux_s7 <= ax + ms_side[191:128];
			ay_s7 <= ay;
			ds_s7 <= ms_side[63:0] - ms_side[127:64];
			us_s7 <= ms_side[63:0] + ms_side[127:64];
		end
	end

	// lane 0 difference vector, lane 1 sum vector
	for (genvar l = 0; l < 2; l++) begin : g_mag
		hav_cordic #(.STEPS(STEPS), .VECTOR(1'b1), .SW(64)) u_vec_a (
			.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s7),
			.x_in((l == 0) ? dx_s7 : ux_s7), .y_in(ay_s7), .z_in('0),
			.side_in((l == 0) ? ds_s7 : us_s7),
			.out_valid(va_v[l]), .x_out(va_x[l]), .y_out(), .z_out(), .side_out(va_s[l])
		);

		hav_qmul #(.SW(64)) u_gain_a (
			.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(&va_v),
			.a(va_x[l]), .b(KINV_Q60), .side_in(va_s[l]),
			.out_valid(ka_v[l]), .p(ka_p[l]), .side_out(ka_s[l])
		);

		hav_cordic #(.STEPS(STEPS), .VECTOR(1'b1), .SW(1)) u_vec_b (
			.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(&ka_v),
			.x_in(ka_p[l]), .y_in(ka_s[l]), .z_in('0), .side_in(1'b0),
			.out_valid(vb_v[l]), .x_out(vb_x[l]), .y_out(), .z_out(), .side_out()
		);

		hav_qmul #(.SW(1)) u_gain_b (
			.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(&vb_v),
			.a(vb_x[l]), .b(KINV_Q60), .side_in(1'b0),
			.out_valid(kb_v[l]), .p(kb_p[l]), .side_out()
		);
	end

	// half central angle from (|sum|, |difference|)
	hav_cordic #(.STEPS(STEPS), .VECTOR(1'b1), .SW(1)) u_vec_c (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(&kb_v),
		.x_in(kb_p[1]), .y_in(kb_p[0]), .z_in('0), .side_in(1'b0),
		.out_valid(vc_v), .x_out(), .y_out(), .z_out(vc_z), .side_out()
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s8 <= vc_z <<< 1;
		end
	end

	hav_qmul #(.SW(1)) u_scale (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s8),
		.a(c_s8), .b(RADIUS_M), .side_in(1'b0),
		.out_valid(kc_v), .p(kc_p), .side_out()
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			priority if (kc_p < 0) begin
				dist_q <= '0;
			end else if (kc_p > q60_t'(DIST_MAX)) begin
				dist_q <= DIST_MAX;
			end else begin
				dist_q <= kc_p[DIST_W-1:0];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-DIST_W){1'b0}}, dist_q};

`ifndef NO_ASSERTIONS
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> dist_q <= DIST_MAX)
		else $error("distance above clamp limit");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !s_tready)
		else $error("input taken while output stalled");

	a_theta: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (theta_s5[0] < HALF_PI && theta_s5[1] < HALF_PI && theta_s5[2] < HALF_PI))
		else $error("reduced angle outside first quadrant");

	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		(rot_v != 3'b000) |-> (rot_v == 3'b111))
		else $error("cordic lanes out of step");
`endif

endmodule

// ===== dv/hav_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_checker
// watches the position and distance streams and the register port, works out
// each expected distance with its own fixed-point cordic model and compares
// the returned distances in order
// ----------------------------------------------------------------------------
module hav_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [21:0] cfg_data,
	output int          errors,
	output int          pending
);
	import hav_pkg::*;

	localparam longint PI_Q    = PI_Q60;
	localparam longint KINV_Q  = KINV_Q60;
	localparam longint TURN    = 3600000;
	localparam longint QUARTER = 900000;
	localparam longint HALF    = 1800000;

	longint atan_tab [CORDIC_STEPS];
	logic signed [LAT_W-1:0] home_lat;
	logic signed [LON_W-1:0] home_lon;
	logic [DIST_W-1:0] distance_q [$];

	initial begin
		longint sum;
		longint term;
		int e;
		atan_tab[0] = PI_Q / 4;
		for (int i = 1; i < CORDIC_STEPS; i++) begin
			sum = 0;
			for (int k = 0; k < 31; k++) begin
				e = 60 - i * (2 * k + 1);
				if (e >= 0) begin
					term = (longint'(1) << e) / longint'(2 * k + 1);
					sum = (k % 2 == 1) ? sum - term : sum + term;
				end
			end
			atan_tab[i] = sum;
		end
	end

	// q60 product, rounded half away from zero
	function automatic longint mul_q60(longint a, longint b);
		logic neg;
		logic [63:0] ua;
		logic [63:0] ub;
		logic [127:0] p;
		logic [63:0] m;
		neg = (a < 0) != (b < 0);
		ua = a < 0 ? 64'(-a) : 64'(a);
		ub = b < 0 ? 64'(-b) : 64'(b);
		p = {64'd0, ua} * {64'd0, ub};
		p = p + (128'd1 << 59);
		if (|p[127:123])
			m = 64'h7FFF_FFFF_FFFF_FFFF;
		else
			m = {1'b0, p[122:60]};
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic void rotate_angle(longint ticks, output longint sn,
			output longint cs);
		longint r, q, rem, x, y, z, t, dx, dy;
		r = ticks % TURN;
		if (r < 0)
			r += TURN;
		q = r / QUARTER;
		rem = r % QUARTER;
		z = rem * (PI_Q / HALF) + (rem * (PI_Q % HALF)) / HALF;
		x = KINV_Q;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[i];
			end else begin
				x += dx; y -= dy; z += atan_tab[i];
			end
		end
		if (q == 1) begin
			t = x; x = -y; y = t;
		end else if (q == 2) begin
			x = -x; y = -y;
		end else if (q == 3) begin
			t = x; x = y; y = -t;
		end
		sn = y;
		cs = x;
	endfunction

	function automatic longint magnitude(longint xi, longint yi, output longint ang);
		longint x, y, z, dx, dy;
		x = xi < 0 ? -xi : xi;
		y = yi < 0 ? -yi : yi;
		z = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atan_tab[i];
			end else begin
				x -= dx; y += dy; z -= atan_tab[i];
			end
		end
		ang = z;
		return mul_q60(x, KINV_Q);
	endfunction

	function automatic logic [DIST_W-1:0] great_circle_m(
			logic signed [LAT_W-1:0] lat1, logic signed [LON_W-1:0] lon1,
			logic signed [LAT_W-1:0] lat2, logic signed [LON_W-1:0] lon2);
		longint s1, c1, s2, c2, sd, cd, ax, ay, dm, um, ang, m;
		rotate_angle(longint'(lat1), s1, c1);
		rotate_angle(longint'(lat2), s2, c2);
		rotate_angle(longint'(lon2) - longint'(lon1), sd, cd);
		ax = mul_q60(c2, cd);
		ay = mul_q60(c2, sd);
		dm = magnitude(magnitude(ax - c1, ay, ang), s2 - s1, ang);
		um = magnitude(magnitude(ax + c1, ay, ang), s2 + s1, ang);
		void'(magnitude(um, dm, ang));
		m = mul_q60(2 * ang, longint'(RADIUS_M));
		if (m < 0)
			m = 0;
		if (m > longint'(DIST_MAX))
			m = longint'(DIST_MAX);
		return m[DIST_W-1:0];
	endfunction

	assign pending = distance_q.size();

	always_ff @(posedge clk or negedge arst_n) begin
		logic [DIST_W-1:0] want;
		if (!arst_n) begin
			home_lat <= REF_LAT_RESET;
			home_lon <= REF_LON_RESET;
			distance_q.delete();
			errors <= 0;
		end else begin
			if (cfg_we && cfg_index == REG_REF_LAT)
				home_lat <= cfg_data[LAT_W-1:0];
			else if (cfg_we && cfg_index == REG_REF_LON)
				home_lon <= cfg_data[LON_W-1:0];
			if (s_tvalid && s_tready)
				distance_q.push_back(great_circle_m(home_lat, home_lon,
					s_tdata[20:0], s_tdata[42:21]));
			if (m_tvalid && m_tready) begin
				if (distance_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected distance item %0d", m_tdata[DIST_W-1:0]);
					errors <= errors + 1;
				end else begin
					want = distance_q.pop_front();
					if (m_tdata[DIST_W-1:0] !== want) begin
						if (errors < 10)
							$display("distance_m mismatch: expected %0d got %0d",
								want, m_tdata[DIST_W-1:0]);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the haversine distance core: directed corner positions, then
// random positions under several reference points and handshake profiles
// ----------------------------------------------------------------------------
module tb_top;
	import hav_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;
	localparam int LONG_HOLD = 600;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [21:0] cfg_data = '0;
	int          errors;
	int          pending;
	int          src_idle = 0;
	int          snk_idle = 0;
	logic        hold_on = 1'b0;
	int          hold_cnt = 0;
	logic signed [LAT_W-1:0] home_lat = REF_LAT_RESET;
	logic signed [LON_W-1:0] home_lon = REF_LON_RESET;

	always #10 clk = ~clk;

	haversine_distance_core dut (.*);

	hav_checker checker_i (.*);

	// receiver, with one long hold-off
	always @(posedge clk) begin
		if (hold_on && hold_cnt < LONG_HOLD) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle);
		end
	end

	initial begin
		#20ms;
		$display("tb_top: FAIL");
		$finish;
	end

	task automatic send_pos(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, lon, lat};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [21:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_REF_LAT)
			home_lat <= val[LAT_W-1:0];
		else if (idx == REG_REF_LON)
			home_lon <= val[LON_W-1:0];
		@(posedge clk);
	endtask

	task automatic set_home(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon);
		drain();
		write_reg(REG_REF_LAT, {1'($urandom_range(1)), lat});
		write_reg(REG_REF_LON, lon);
	endtask

	task automatic random_pos;
		logic signed [LAT_W-1:0] lat;
		logic signed [LON_W-1:0] lon;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				lat = $signed(21'($urandom_range(1800000))) - 21'sd900000;
				lon = $signed(22'($urandom_range(3600000))) - 22'sd1800000;
			end
			4, 5: begin
				lat = home_lat + $signed(21'($urandom_range(2000))) - 21'sd1000;
				lon = home_lon + $signed(22'($urandom_range(2000))) - 22'sd1000;
			end
			6: begin
				lat = -home_lat + $signed(21'($urandom_range(20))) - 21'sd10;
				lon = home_lon + 22'sd1800000 + $signed(22'($urandom_range(20))) - 22'sd10;
			end
			7: begin
				lat = home_lat;
				lon = home_lon;
			end
			default: begin
				lat = 21'($urandom);
				lon = 22'($urandom);
			end
		endcase
		send_pos(lat, lon);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners under the reset reference point, then under pole reference points, then unused register writes
		send_pos(REF_LAT_RESET, REF_LON_RESET);
		send_pos(-REF_LAT_RESET, REF_LON_RESET - 22'sd1800000);
		send_pos(21'sd900000, 22'sd0);
		send_pos(-21'sd900000, 22'sd0);
		send_pos(21'sd0, 22'sd1800000);
		send_pos(21'sd0, -22'sd1800000);
		send_pos(21'sd0, 22'sd0);
		send_pos(21'h0F_FFFF, 22'h1F_FFFF);
		send_pos(21'h10_0000, 22'h20_0000);
		send_pos(21'h1F_FFFF, 22'h3F_FFFF);
		send_pos(21'sd450000, -22'sd1700000);
		send_pos(21'sd1000000, 22'sd2000000);
		drain();
		set_home(21'sd900000, 22'sd1800000);
		send_pos(21'sd900000, 22'sd1800000);
		send_pos(-21'sd900000, -22'sd1800000);
		send_pos(21'sd900000, 22'sd0);
		send_pos(21'sd0, -22'sd1800000);
		set_home(-21'sd900000, -22'sd1800000);
		send_pos(-21'sd900000, -22'sd1800000);
		send_pos(21'sd900000, 22'sd1800000);
		send_pos(21'sd0, 22'sd0);
		drain();
		write_reg(REG_UNUSED, 22'h3F_FFFF);
		write_reg(REG_UNUSED + 2'd1, 22'h15_5555);
		send_pos(21'sd0, 22'sd0);

		// long receiver hold-off while positions keep coming
		hold_on <= 1'b1;
		repeat (300) send_pos(21'($urandom), 22'($urandom));
		drain();

		src_idle = 31;
		snk_idle = 51;
		set_home($signed(21'($urandom_range(1800000))) - 21'sd900000,
			$signed(22'($urandom_range(3600000))) - 22'sd1800000);
		repeat (300) random_pos();

		src_idle = 51;
		snk_idle = 31;
		set_home(REF_LAT_RESET, REF_LON_RESET);
		repeat (300) random_pos();

		src_idle = 0;
		snk_idle = 0;
		set_home(-21'sd900000, 22'sd1800000);
		repeat (250) random_pos();

		drain();
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
